// ===== rtl/modified_utf8_byte_repair_core_defines.svh =====
// Assertion macros used by the checker.
`ifndef MODIFIED_UTF8_BYTE_REPAIR_CORE_DEFINES_SVH
`define MODIFIED_UTF8_BYTE_REPAIR_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MUB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MUB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mub_pkg.sv =====
package mub_pkg;

    localparam int COUNT_BITS  = 31;
    localparam int OUT_BITS    = 31;
    localparam int CFG_BITS    = 31;
    localparam int PEND_DEPTH  = 5;
    localparam int BUF_DEPTH   = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [OUT_BITS-1:0] OUT_MAX       = '1;
    localparam logic [CFG_BITS-1:0] MAX_CHARS_RST = '1;

    localparam logic [7:0] LEAD_C0     = 8'b11000000;
    localparam logic [7:0] CONT_80     = 8'b10000000;
    localparam logic [7:0] LEAD_E0     = 8'b11100000;
    localparam logic [7:0] LEAD_ED     = 8'b11101101;
    localparam logic [7:0] ASCII_MASK  = 8'h7F;
    localparam logic [7:0] LOWLEAD_MSK = 8'b00011110;
    localparam logic [7:0] BACKSLASH   = 8'h5C;
    localparam logic [7:0] CONT_SET    = 8'h80;
    localparam logic [7:0] CONT_KEEP   = 8'hBF;
    localparam logic [7:0] BIT_40      = 8'h40;
    localparam logic [7:0] MASK_DF     = 8'hDF;
    localparam logic [7:0] MASK_EF     = 8'hEF;
    localparam logic [7:0] BIT_20      = 8'h20;
    localparam logic [7:0] BITS_30     = 8'h30;
    localparam logic [7:0] BIT_02      = 8'h02;

    typedef enum logic [1:0] {
        REG_ASCII_ONLY = 2'd0,
        REG_STOP_BS    = 2'd1,
        REG_MAX_CHARS  = 2'd2
    } t_reg_idx;

    typedef enum logic [11:0] {
        ST_LEAD            = 12'b000000000001,
        ST_AFTER_BS        = 12'b000000000010,
        ST_CONT            = 12'b000000000100,
        ST_CONT_LOWLEAD    = 12'b000000001000,
        ST_FIRST_LOWLEAD   = 12'b000000010000,
        ST_FIRST_SURR      = 12'b000000100000,
        ST_FIRST           = 12'b000001000000,
        ST_SECOND          = 12'b000010000000,
        ST_LEAD_LOWSURR    = 12'b000100000000,
        ST_FIRST_LOWSURR   = 12'b001000000000,
        ST_SECOND_HIGHSURR = 12'b010000000000,
        ST_SECOND_LOWSURR  = 12'b100000000000
    } t_fix_state;

    typedef struct packed {
        logic                 we;
        logic [1:0]           idx;
        logic [CFG_BITS-1:0]  data;
    } t_cfg_wr;

    typedef struct packed {
        logic [BUF_DEPTH-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      done;
        logic [OUT_BITS-1:0]       consumed;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_qwr;

    typedef struct packed {
        logic full;
        logic empty;
        t_job head;
    } t_qstat;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
    endfunction

    function automatic logic [7:0] force_cont(input logic [7:0] v);
        return (v | CONT_SET) & CONT_KEEP;
    endfunction

endpackage

// ===== rtl/mub_if.sv =====
interface mub_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface mub_out_if import mub_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                run_last;
    logic                string_end;
    logic [OUT_BITS-1:0] consumed_count;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output string_end, output consumed_count, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input string_end, input consumed_count, output ready);
endinterface

// ===== rtl/mub_front.sv =====
module mub_front import mub_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg_wr  i_cfg,
    mub_in_if.sink   i_in,
    input  logic     i_full,
    output t_qwr     o_qwr
);

    logic                  r_ascii;
    logic                  r_stop_bs;
    logic [CFG_BITS-1:0]   r_max;
    t_fix_state            r_st;
    logic [7:0]            r_pend [PEND_DEPTH];
    logic [2:0]            r_pcnt;
    logic [COUNT_BITS-1:0] r_char;
    logic [COUNT_BITS-1:0] r_consumed;
    logic                  r_fresh;

    t_fix_state                n_st;
    logic [BUF_DEPTH-1:0][7:0] b;
    logic [2:0]                n_cnt;
    logic [COUNT_BITS-1:0]     n_char;
    logic [COUNT_BITS-1:0]     consumed;
    logic [CFG_BITS-1:0]       limit;
    logic                      fresh_last;
    logic                      stop;
    logic                      fin;
    logic                      emit;
    logic                      accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        logic [7:0] cc;
        logic [2:0] cnt;
        logic [2:0] last_idx;
        logic       append;
        logic       two;
        logic       inc;
        cc       = r_ascii ? (i_in.in_byte & ASCII_MASK) : i_in.in_byte;
        cnt      = r_pcnt;
        last_idx = cnt - 3'd1;
        append   = 1'b1;
        two      = 1'b0;
        inc      = 1'b0;
        stop     = 1'b0;
        n_st     = r_st;
        consumed = sat_inc(r_consumed);
        limit    = (r_max == '0) ? CFG_BITS'(1) : r_max;
        fresh_last = r_fresh && i_in.in_last;
        b = '0;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            b[i] = r_pend[i];
        end

        unique case (r_st)
            ST_AFTER_BS: begin
                if (cc != BACKSLASH) begin
                    stop   = 1'b1;
                    append = 1'b0;
                end else begin
                    n_st = ST_LEAD;
                    inc  = 1'b1;
                end
            end
            ST_CONT_LOWLEAD: begin
                cc = force_cont(cc);
                if (cnt != 3'd0 && !(b[last_idx] == LEAD_C0 && cc == CONT_80)) begin
                    b[last_idx] = b[last_idx] | BIT_02;
                end
                n_st = ST_LEAD;
                inc  = 1'b1;
            end
            ST_CONT, ST_SECOND, ST_SECOND_LOWSURR: begin
                cc   = force_cont(cc);
                n_st = ST_LEAD;
                inc  = 1'b1;
            end
            ST_FIRST_LOWLEAD: begin
                cc   = force_cont(cc) | BIT_20;
                n_st = ST_SECOND;
            end
            ST_FIRST_SURR: begin
                cc = force_cont(cc);
                if (cc[5]) begin
                    cc   = cc & MASK_EF;
                    n_st = ST_SECOND_HIGHSURR;
                end else begin
                    n_st = ST_SECOND;
                end
            end
            ST_FIRST: begin
                cc   = force_cont(cc);
                n_st = ST_SECOND;
            end
            ST_SECOND_HIGHSURR: begin
                cc   = force_cont(cc);
                n_st = ST_LEAD_LOWSURR;
                inc  = 1'b1;
            end
            ST_LEAD_LOWSURR: begin
                cc   = LEAD_ED;
                n_st = ST_FIRST_LOWSURR;
            end
            ST_FIRST_LOWSURR: begin
                cc   = force_cont(cc) | BITS_30;
                n_st = ST_SECOND_LOWSURR;
            end
            ST_LEAD: begin
                n_st = ST_LEAD;
                priority if (!cc[7]) begin
                    if (cc == 8'd0) begin
                        two = 1'b1;
                        inc = 1'b1;
                    end else if (r_stop_bs && cc == BACKSLASH) begin
                        n_st   = ST_AFTER_BS;
                        append = 1'b0;
                    end else begin
                        inc = 1'b1;
                    end
                end else if (!cc[6] || !cc[5]) begin
                    if (!cc[6]) begin
                        cc = (cc | BIT_40) & MASK_DF;
                    end
                    n_st = ((cc & LOWLEAD_MSK) == 8'd0) ? ST_CONT_LOWLEAD : ST_CONT;
                end else begin
                    if (cc[4]) begin
                        cc = cc & MASK_EF;
                    end
                    priority if (cc == LEAD_E0) begin
                        n_st = ST_FIRST_LOWLEAD;
                    end else if (cc == LEAD_ED) begin
                        n_st = ST_FIRST_SURR;
                    end else begin
                        n_st = ST_FIRST;
                    end
                end
            end
            default: begin
                n_st   = ST_LEAD;
                append = 1'b0;
            end
        endcase

        for (int i = 0; i < BUF_DEPTH; i++) begin
            if (append && 3'(i) == cnt) begin
                b[i] = two ? LEAD_C0 : cc;
            end
            if (append && two && 3'(i) == cnt + 3'd1) begin
                b[i] = CONT_80;
            end
        end
        n_cnt  = cnt + {2'b0, append} + {2'b0, append & two};
        n_char = inc ? sat_inc(r_char) : r_char;
        emit   = !stop && (n_st == ST_LEAD || n_st == ST_AFTER_BS);
        fin    = fresh_last || stop || (64'(n_char) >= 64'(limit)) || i_in.in_last;

        o_qwr.push         = accept;
        o_qwr.job.bytes    = b;
        o_qwr.job.nbytes   = (emit && !fresh_last) ? n_cnt : 3'd0;
        o_qwr.job.done     = fin;
        o_qwr.job.consumed = clamp_out(consumed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii   <= 1'b0;
            r_stop_bs <= 1'b0;
            r_max     <= MAX_CHARS_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_ASCII_ONLY: r_ascii   <= i_cfg.data[0];
                REG_STOP_BS:    r_stop_bs <= i_cfg.data[0];
                REG_MAX_CHARS:  r_max     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_LEAD;
            r_pcnt     <= 3'd0;
            r_char     <= '0;
            r_consumed <= '0;
            r_fresh    <= 1'b1;
        end else if (accept) begin
            if (fin) begin
                r_st       <= ST_LEAD;
                r_pcnt     <= 3'd0;
                r_char     <= '0;
                r_consumed <= '0;
                r_fresh    <= 1'b1;
            end else begin
                r_st       <= n_st;
                r_pcnt     <= emit ? 3'd0 : ((n_cnt > 3'(PEND_DEPTH)) ? 3'(PEND_DEPTH) : n_cnt);
                r_char     <= n_char;
                r_consumed <= consumed;
                r_fresh    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
                r_pend[i] <= b[i];
            end
        end
    end

endmodule

// ===== rtl/mub_queue.sv =====
module mub_queue import mub_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qwr   i_qwr,
    input  logic   i_pop,
    output t_qstat o_qstat
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QPTR_BITS:0]   r_cnt;
    logic                 push;
    logic                 pop;

    assign o_qstat.full  = (r_cnt == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.head  = r_mem[r_rd];
    assign push = i_qwr.push && !o_qstat.full;
    assign pop  = i_pop && !o_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + {{QPTR_BITS{1'b0}}, push} - {{QPTR_BITS{1'b0}}, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_qwr.job;
        end
    end

endmodule

// ===== rtl/mub_back.sv =====
module mub_back import mub_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    mub_out_if.source  o_out
);

    logic                r_ov;
    logic [7:0]          r_byte;
    logic                r_bv;
    logic                r_last;
    logic                r_end;
    logic [OUT_BITS-1:0] r_cons;
    logic [2:0]          r_k;

    logic load;
    logic extra;
    logic is_byte;
    logic is_last;

    assign extra   = i_qstat.head.done || (i_qstat.head.nbytes == 3'd0);
    assign is_byte = r_k < i_qstat.head.nbytes;
    assign is_last = extra ? (r_k == i_qstat.head.nbytes)
                           : (r_k == i_qstat.head.nbytes - 3'd1);
    assign load    = !i_qstat.empty && (!r_ov || o_out.ready);
    assign o_pop   = load && is_last;

    assign o_out.valid          = r_ov;
    assign o_out.out_byte       = r_byte;
    assign o_out.byte_valid     = r_bv;
    assign o_out.run_last       = r_last;
    assign o_out.string_end     = r_end;
    assign o_out.consumed_count = r_cons;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_k  <= 3'd0;
        end else if (load) begin
            r_ov <= 1'b1;
            r_k  <= is_last ? 3'd0 : r_k + 3'd1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= is_byte ? i_qstat.head.bytes[r_k] : 8'd0;
            r_bv   <= is_byte;
            r_end  <= !is_byte && i_qstat.head.done;
            r_last <= is_last;
            r_cons <= i_qstat.head.consumed;
        end
    end

endmodule

// ===== rtl/modified_utf8_byte_repair_core.sv =====
// Channel   Dir  Beat payload
// i_in      in   in_byte[7:0], in_last
// o_out     out  out_byte[7:0], byte_valid, run_last, string_end, consumed_count[30:0]
// i_cfg_*   in   write enable, register index[1:0], data[30:0]
//
// Each input byte is classified combinationally and yields 1 to 7 result beats.
// The output stage sends one beat per cycle while the sink is ready; a 4-entry
// job queue absorbs bursts.
// Reset is synchronous; state returns to the leading-byte state of a new string.
// Input stalls only when the job queue is full; output stalls hold the beat.
module modified_utf8_byte_repair_core import mub_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mub_in_if.sink              i_in,
    mub_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    t_cfg_wr cfg;
    t_qwr    qwr;
    t_qstat  qstat;
    logic    pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    mub_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_full  (qstat.full),
        .o_qwr   (qwr)
    );

    mub_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (pop),
        .o_qstat (qstat)
    );

    mub_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/mub_checker.sv =====
`include "modified_utf8_byte_repair_core_defines.svh"

module mub_checker import mub_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [7:0]          i_out_byte,
    input logic                i_byte_valid,
    input logic                i_run_last,
    input logic                i_string_end,
    input logic [OUT_BITS-1:0] i_consumed_count
);

    `MUB_ASSERT_IMPL(a_end_is_last, i_clk, i_rst_n, i_out_valid && i_string_end, !i_byte_valid && i_run_last, "end marker must be a non-byte last beat")
    `MUB_ASSERT_IMPL(a_idle_is_last, i_clk, i_rst_n, i_out_valid && !i_byte_valid, i_run_last && i_out_byte == 8'd0, "non-byte beat must be last and zero")
    `MUB_ASSERT_IMPL(a_consumed_nz, i_clk, i_rst_n, i_out_valid, i_consumed_count != '0, "consumed count must be nonzero")
    `MUB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_consumed_count), "stalled beat changed")

endmodule

bind modified_utf8_byte_repair_core mub_checker u_mub_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_byte_valid     (o_out.byte_valid),
    .i_run_last       (o_out.run_last),
    .i_string_end     (o_out.string_end),
    .i_consumed_count (o_out.consumed_count)
);
